### rtl/tsm_pkg.sv
// Shared types and constants for the timestamp text to minutes block.
// Used by tsm_parse, tsm_days and timestamp_text_to_minutes; no dependencies.
package tsm_pkg;

  localparam int TEXT_LEN   = 19;
  localparam int POS_W      = 5;
  localparam int YEAR_W     = 14;
  localparam int FIELD_W    = 7;
  localparam int HM_W       = 13;
  localparam int DAYS_W     = 23;
  localparam int MINUTES_W  = 34;
  localparam int PIPE_STAGES = 6;

  // Reciprocals for the constant divisions: floor(x / d) == (x * K) >> S
  // over the value ranges that reach each divider.
  localparam logic [15:0] ERA_RECIP = 16'd41944;   // 1/400, shift 24
  localparam int          ERA_SHIFT = 24;
  localparam logic [14:0] DIV5_RECIP = 15'd26215;  // 1/5, shift 17
  localparam int          DIV5_SHIFT = 17;
  localparam logic [9:0]  DIV100_RECIP = 10'd656;  // 1/100, shift 16
  localparam int          DIV100_SHIFT = 16;

  localparam logic [21:0] DAYS_PER_ERA = 22'd146097;
  localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [7:0]  MONTH_DAYS_MUL = 8'd153;
  localparam logic [10:0] MIN_PER_DAY = 11'd1440;
  localparam logic signed [MINUTES_W-1:0] MINUTES_MIN = -34'sd132480;

  // Digit fields collected from one text.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic               ok;
  } fields_t;

  // Day number and time of day, ready for the final scaling.
  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [HM_W-1:0]   hm;
    logic              ok;
  } days_t;

endpackage

### rtl/tsm_parse.sv
// Character parser: tracks the position in the text and collects the digit fields.
// Depends on tsm_pkg; feeds one fields_t item per text to tsm_days.
module tsm_parse import tsm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         char_valid,
  output logic         char_ready,
  input  logic [7:0]   char_code,
  input  logic         last_char,
  output logic         fld_valid,
  input  logic         fld_ready,
  output fields_t      fld
);

  logic [POS_W-1:0]   position, position_next;
  logic [YEAR_W-1:0]  year_acc, year_acc_next;
  logic [FIELD_W-1:0] month_acc, month_acc_next;
  logic [FIELD_W-1:0] day_acc, day_acc_next;
  logic [FIELD_W-1:0] hour_acc, hour_acc_next;
  logic [FIELD_W-1:0] minute_acc, minute_acc_next;
  logic               bad_digit, bad_digit_next;
  logic               take;
  logic               is_digit;
  logic [3:0]         digit;

  function automatic logic [YEAR_W-1:0] dec_step(input logic [YEAR_W-1:0] acc,
                                                 input logic [3:0] dig);
    dec_step = (acc << 3) + (acc << 1) + YEAR_W'(dig);
  endfunction

  assign char_ready = !fld_valid || fld_ready;
  assign take       = char_valid && char_ready;
  assign is_digit   = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign digit      = char_code[3:0];

  always_comb begin
    position_next   = position;
    year_acc_next   = year_acc;
    month_acc_next  = month_acc;
    day_acc_next    = day_acc;
    hour_acc_next   = hour_acc;
    minute_acc_next = minute_acc;
    bad_digit_next  = bad_digit;
    if (take) begin
      if (position < POS_W'(TEXT_LEN)) begin
        position_next = position + POS_W'(1);
        case (position) inside
          [5'd0:5'd3]: begin
            if (is_digit) year_acc_next = dec_step(year_acc, digit);
            else bad_digit_next = 1'b1;
          end
          5'd5, 5'd6: begin
            if (is_digit) month_acc_next = FIELD_W'(dec_step(YEAR_W'(month_acc), digit));
            else bad_digit_next = 1'b1;
          end
          5'd8, 5'd9: begin
            if (is_digit) day_acc_next = FIELD_W'(dec_step(YEAR_W'(day_acc), digit));
            else bad_digit_next = 1'b1;
          end
          5'd11, 5'd12: begin
            if (is_digit) hour_acc_next = FIELD_W'(dec_step(YEAR_W'(hour_acc), digit));
            else bad_digit_next = 1'b1;
          end
          5'd14, 5'd15: begin
            if (is_digit) minute_acc_next = FIELD_W'(dec_step(YEAR_W'(minute_acc), digit));
            else bad_digit_next = 1'b1;
          end
          default: begin
          end
        endcase
      end
      // The text ends here; start over for the next one.
      if (last_char) begin
        position_next   = '0;
        year_acc_next   = '0;
        month_acc_next  = '0;
        day_acc_next    = '0;
        hour_acc_next   = '0;
        minute_acc_next = '0;
        bad_digit_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      year_acc   <= '0;
      month_acc  <= '0;
      day_acc    <= '0;
      hour_acc   <= '0;
      minute_acc <= '0;
      bad_digit  <= 1'b0;
      fld_valid  <= 1'b0;
    end else begin
      position   <= position_next;
      year_acc   <= year_acc_next;
      month_acc  <= month_acc_next;
      day_acc    <= day_acc_next;
      hour_acc   <= hour_acc_next;
      minute_acc <= minute_acc_next;
      bad_digit  <= bad_digit_next;
      if (char_ready) fld_valid <= take && last_char;
    end
  end

  // The last character of a complete text sits past every digit position,
  // so the fields are already final when it arrives.
  always_ff @(posedge clk) begin
    if (take && last_char) begin
      fld.year   <= year_acc;
      fld.month  <= month_acc;
      fld.day    <= day_acc;
      fld.hour   <= hour_acc;
      fld.minute <= minute_acc;
      fld.ok     <= (position >= POS_W'(TEXT_LEN - 1)) && !bad_digit;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= POS_W'(TEXT_LEN))
    else $error("text position ran past the end of the text");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    take && last_char |=> position == '0 && !bad_digit && year_acc == '0)
    else $error("parser state not cleared after the last character");

endmodule

### rtl/tsm_days.sv
// Day-number pipeline: civil date to days since 0000-03-01, plus hour and minute.
// Depends on tsm_pkg; takes fields_t from tsm_parse, gives days_t to the top level.
module tsm_days import tsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  output logic    up_ready,
  input  fields_t up,
  output logic    dn_valid,
  input  logic    dn_ready,
  output days_t   dn
);

  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES:0]   rdy;

  // Stage 1: year shifted by one era, month index from March, time of day.
  logic [YEAR_W-1:0]  s1_yy;
  logic [FIELD_W-1:0] s1_mp, s1_day;
  logic [HM_W-1:0]    s1_hm;
  logic               s1_ok;
  // Stage 2: era (plus one) and month-start term.
  logic [YEAR_W-1:0]  s2_yy;
  logic [4:0]         s2_era;
  logic [14:0]        s2_t;
  logic [FIELD_W-1:0] s2_day;
  logic [HM_W-1:0]    s2_hm;
  logic               s2_ok;
  // Stage 3: year of era and day of year.
  logic [4:0]         s3_era;
  logic [8:0]         s3_yoe;
  logic [12:0]        s3_doy;
  logic [HM_W-1:0]    s3_hm;
  logic               s3_ok;
  // Stage 4: year days with leap days, and the century correction.
  logic [4:0]         s4_era;
  logic [17:0]        s4_a;
  logic [1:0]         s4_c;
  logic [12:0]        s4_doy;
  logic [HM_W-1:0]    s4_hm;
  logic               s4_ok;
  // Stage 5: day of era and the era offset.
  logic [21:0]        s5_eraterm;
  logic [18:0]        s5_doe;
  logic [HM_W-1:0]    s5_hm;
  logic               s5_ok;

  logic               borrow;
  logic [29:0]        era_prod, q5_prod;
  logic [18:0]        c_prod;
  logic [11:0]        q5;

  // Each stage loads when it is empty or its successor moves on.
  always_comb begin
    rdy[PIPE_STAGES] = dn_ready;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end
  assign up_ready = rdy[0];
  assign dn_valid = vld[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= up_valid;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // January and February count as months of the year before.
  assign borrow   = up.month <= FIELD_W'(2);
  assign era_prod = 30'(s1_yy) * 30'(ERA_RECIP);
  assign q5_prod  = 30'(s2_t) * 30'(DIV5_RECIP);
  assign q5       = 12'(q5_prod >> DIV5_SHIFT);
  assign c_prod   = 19'(s3_yoe) * 19'(DIV100_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_yy  <= up.year + YEAR_W'(YEARS_PER_ERA) - YEAR_W'(borrow);
      s1_mp  <= borrow ? up.month + FIELD_W'(9) : up.month - FIELD_W'(3);
      s1_day <= up.day;
      s1_hm  <= (HM_W'(up.hour) << 6) - (HM_W'(up.hour) << 2) + HM_W'(up.minute);
      s1_ok  <= up.ok;
    end
    if (rdy[1]) begin
      s2_yy  <= s1_yy;
      s2_era <= 5'(era_prod >> ERA_SHIFT);
      s2_t   <= 15'(s1_mp) * 15'(MONTH_DAYS_MUL) + 15'd2;
      s2_day <= s1_day;
      s2_hm  <= s1_hm;
      s2_ok  <= s1_ok;
    end
    if (rdy[2]) begin
      s3_era <= s2_era;
      s3_yoe <= 9'(s2_yy - YEAR_W'(s2_era) * YEAR_W'(YEARS_PER_ERA));
      s3_doy <= {1'b0, q5} + {6'b0, s2_day} - 13'd1;
      s3_hm  <= s2_hm;
      s3_ok  <= s2_ok;
    end
    if (rdy[3]) begin
      s4_era <= s3_era;
      s4_a   <= 18'(s3_yoe) * 18'(DAYS_PER_YEAR) + 18'(s3_yoe >> 2);
      s4_c   <= 2'(c_prod >> DIV100_SHIFT);
      s4_doy <= s3_doy;
      s4_hm  <= s3_hm;
      s4_ok  <= s3_ok;
    end
    if (rdy[4]) begin
      s5_eraterm <= 22'(s4_era) * DAYS_PER_ERA;
      s5_doe     <= {1'b0, s4_a} - 19'(s4_c) + {{6{s4_doy[12]}}, s4_doy};
      s5_hm      <= s4_hm;
      s5_ok      <= s4_ok;
    end
    if (rdy[5]) begin
      // The era was counted from one era early; take that era back off here.
      dn.days <= {1'b0, s5_eraterm} - {1'b0, DAYS_PER_ERA}
                 + {{(DAYS_W-19){s5_doe[18]}}, s5_doe};
      dn.hm   <= s5_hm;
      dn.ok   <= s5_ok;
    end
  end

endmodule

### rtl/timestamp_text_to_minutes.sv
// Top level: timestamp text in, minutes since 0000-03-01 out.
// Depends on tsm_pkg, tsm_parse and tsm_days.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------
//   input    | char_valid / char_ready   | char_code, last_char
//   result   | result_valid / result_ready | minutes, valid_res
//
// One character is taken every cycle while char_ready is high, one result per text.
// The fields register loads on the edge that accepts the item with last_char set;
// six date pipeline stages and then the output register, which also holds the
// final days-to-minutes multiply, follow it before result_valid rises.
// Reset (rst, synchronous) clears the text position, the collected fields
// and every stage valid bit.
// Empty stages close up under a stall, so characters keep flowing until a
// finished text finds every stage ahead of it full.
module timestamp_text_to_minutes import tsm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        char_valid,
  output logic                        char_ready,
  input  logic [7:0]                  char_code,
  input  logic                        last_char,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic signed [MINUTES_W-1:0] minutes,
  output logic                        valid_res
);

  fields_t fld;
  logic    fld_valid, fld_ready;
  days_t   dd;
  logic    dd_valid, dd_ready;
  logic    out_load;
  logic [MINUTES_W-1:0] scaled;

  tsm_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_code  (char_code),
    .last_char  (last_char),
    .fld_valid  (fld_valid),
    .fld_ready  (fld_ready),
    .fld        (fld)
  );

  tsm_days u_days (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fld_valid),
    .up_ready (fld_ready),
    .up       (fld),
    .dn_valid (dd_valid),
    .dn_ready (dd_ready),
    .dn       (dd)
  );

  assign out_load = !result_valid || result_ready;
  assign dd_ready = out_load;
  assign scaled   = {{(MINUTES_W-DAYS_W){dd.days[DAYS_W-1]}}, dd.days}
                    * MINUTES_W'(MIN_PER_DAY) + MINUTES_W'(dd.hm);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= dd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      minutes   <= dd.ok ? $signed(scaled) : '0;
      valid_res <= dd.ok;
    end
  end

  a_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !valid_res |-> minutes == '0)
    else $error("invalid text produced nonzero minutes");

  a_min_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid && valid_res |-> minutes >= MINUTES_MIN)
    else $error("minutes below the smallest reachable value");

endmodule
